@@ rtl/core/pse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pse_pkg;

    localparam int FIRST_PRIME = 2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic
    {
        CMD_RUN  = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef logic [15:0] limit_t;
    typedef logic [12:0] index_t;
    typedef logic [13:0] count_t;
    typedef logic [15:0] value_t;

    typedef struct packed
    {
        cmd_t   command;
        limit_t limit;
        index_t index;
    } req_t;

    typedef struct packed
    {
        logic   status;
        count_t prime_count;
        value_t prime_value;
    } rsp_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CLEAR,
        ST_CHK_RD,
        ST_CHK_TEST,
        ST_MARK,
        ST_CHK_NEXT,
        ST_COLLECT,
        ST_READ
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/pse_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pse_ram #(
    parameter  int DW    = 1,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/pse_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pse_seq #(
    parameter  int LIMIT_CAP  = 65535,
    parameter  int MAX_PRIMES = 8192,
    localparam int VW         = $clog2(LIMIT_CAP + 1),
    localparam int PW         = $clog2(MAX_PRIMES)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire pse_pkg::req_t   request,
    output logic                 done,
    output pse_pkg::rsp_t        response,
    output logic                 mark_we,
    output logic      [VW-1:0]   mark_waddr,
    output logic                 mark_wdata,
    output logic      [VW-1:0]   mark_raddr,
    input  wire logic            mark_rdata,
    output logic                 list_we,
    output logic      [PW-1:0]   list_waddr,
    output logic      [VW-1:0]   list_wdata,
    output logic      [PW-1:0]   list_raddr,
    input  wire logic [VW-1:0]   list_rdata
);

    pse_pkg::state_t state_reg, state_next;
    logic [VW-1:0]   lim_reg, lim_next;
    logic [VW:0]     v_reg, v_next;
    logic [VW:0]     sq_reg, sq_next;
    logic [VW:0]     m_reg, m_next;
    logic [PW:0]     n_reg, n_next;
    logic [PW:0]     count_reg, count_next;
    logic [VW-1:0]   pv_reg, pv_next;
    logic            pv_valid_reg, pv_valid_next;
    pse_pkg::index_t idx_reg, idx_next;
    logic            done_reg, done_next;
    pse_pkg::rsp_t   rsp_reg, rsp_next;

    logic            accept;
    logic [VW-1:0]   clamp_lim;
    logic            small_lim;
    logic [VW:0]     lim_ext;
    logic            v_at_lim, v_in, sq_in, m_in, n_room, hit, out_of_range;
    logic [VW:0]     add_a, add_b, sum;

    assign accept       = start && !busy;
    assign clamp_lim    = (32'(request.limit) > LIMIT_CAP) ? VW'(LIMIT_CAP)
                                                           : VW'(request.limit);
    assign small_lim    = clamp_lim < VW'(pse_pkg::FIRST_PRIME);
    assign lim_ext      = {1'b0, lim_reg};
    assign v_at_lim     = v_reg == lim_ext;
    assign v_in         = v_reg <= lim_ext;
    assign sq_in        = sq_reg <= lim_ext;
    assign m_in         = m_reg <= lim_ext;
    assign n_room       = n_reg < (PW+1)'(MAX_PRIMES);
    assign hit          = pv_valid_reg && !mark_rdata && n_room;
    assign sum          = add_a + add_b;
    assign out_of_range = (32'(idx_reg) >= 32'(count_reg)) || (32'(idx_reg) >= MAX_PRIMES);
    assign done         = done_reg;
    assign response     = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == pse_pkg::CMD_READ)
                    begin
                        state_next = pse_pkg::ST_READ;
                    end
                    else if (!small_lim)
                    begin
                        state_next = pse_pkg::ST_CLEAR;
                    end
                end
            end
            pse_pkg::ST_CLEAR:
            begin
                if (v_at_lim)
                begin
                    state_next = pse_pkg::ST_CHK_RD;
                end
            end
            pse_pkg::ST_CHK_RD:
            begin
                state_next = sq_in ? pse_pkg::ST_CHK_TEST : pse_pkg::ST_COLLECT;
            end
            pse_pkg::ST_CHK_TEST:
            begin
                state_next = mark_rdata ? pse_pkg::ST_CHK_NEXT : pse_pkg::ST_MARK;
            end
            pse_pkg::ST_MARK:
            begin
                if (!m_in)
                begin
                    state_next = pse_pkg::ST_CHK_NEXT;
                end
            end
            pse_pkg::ST_CHK_NEXT:
            begin
                state_next = pse_pkg::ST_CHK_RD;
            end
            pse_pkg::ST_COLLECT:
            begin
                if (!v_in && !pv_valid_reg)
                begin
                    state_next = pse_pkg::ST_IDLE;
                end
            end
            pse_pkg::ST_READ:
            begin
                state_next = pse_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pse_pkg::ST_IDLE;
            end
        endcase
    end

    // memory controls and shared adder operands
    always_comb
    begin
        busy       = state_reg != pse_pkg::ST_IDLE;
        mark_we    = 1'b0;
        mark_waddr = v_reg[VW-1:0];
        mark_wdata = 1'b0;
        mark_raddr = v_reg[VW-1:0];
        list_we    = 1'b0;
        list_waddr = n_reg[PW-1:0];
        list_wdata = pv_reg;
        list_raddr = PW'(request.index);
        add_a      = sq_reg;
        add_b      = {v_reg[VW-1:0], 1'b1};
        case (state_reg)
            pse_pkg::ST_CLEAR:
            begin
                mark_we = 1'b1;
            end
            pse_pkg::ST_MARK:
            begin
                mark_we    = m_in;
                mark_waddr = m_reg[VW-1:0];
                mark_wdata = 1'b1;
                add_a      = m_reg;
                add_b      = v_reg;
            end
            pse_pkg::ST_COLLECT:
            begin
                list_we = hit;
            end
            default:
            begin
                mark_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        lim_next      = lim_reg;
        v_next        = v_reg;
        sq_next       = sq_reg;
        m_next        = m_reg;
        n_next        = n_reg;
        count_next    = count_reg;
        pv_next       = pv_reg;
        pv_valid_next = pv_valid_reg;
        idx_next      = idx_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        case (state_reg)
            pse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.command == pse_pkg::CMD_READ)
                    begin
                        idx_next = request.index;
                    end
                    else
                    begin
                        lim_next = clamp_lim;
                        v_next   = (VW+1)'(pse_pkg::FIRST_PRIME);
                        if (small_lim)
                        begin
                            count_next           = '0;
                            done_next            = 1'b1;
                            rsp_next.status      = pse_pkg::STATUS_OK;
                            rsp_next.prime_count = '0;
                            rsp_next.prime_value = '0;
                        end
                    end
                end
            end
            pse_pkg::ST_CLEAR:
            begin
                if (v_at_lim)
                begin
                    v_next  = (VW+1)'(pse_pkg::FIRST_PRIME);
                    sq_next = (VW+1)'(pse_pkg::FIRST_PRIME * pse_pkg::FIRST_PRIME);
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            pse_pkg::ST_CHK_RD:
            begin
                if (!sq_in)
                begin
                    v_next        = (VW+1)'(pse_pkg::FIRST_PRIME);
                    n_next        = '0;
                    pv_valid_next = 1'b0;
                end
            end
            pse_pkg::ST_CHK_TEST:
            begin
                m_next = sq_reg;
            end
            pse_pkg::ST_MARK:
            begin
                if (m_in)
                begin
                    m_next = sum;
                end
            end
            pse_pkg::ST_CHK_NEXT:
            begin
                sq_next = sum;
                v_next  = v_reg + 1'b1;
            end
            pse_pkg::ST_COLLECT:
            begin
                if (v_in)
                begin
                    pv_next       = v_reg[VW-1:0];
                    pv_valid_next = 1'b1;
                    v_next        = v_reg + 1'b1;
                end
                else
                begin
                    pv_valid_next = 1'b0;
                end
                if (hit)
                begin
                    n_next = n_reg + 1'b1;
                end
                if (!v_in && !pv_valid_reg)
                begin
                    count_next           = n_reg;
                    done_next            = 1'b1;
                    rsp_next.status      = pse_pkg::STATUS_OK;
                    rsp_next.prime_count = pse_pkg::count_t'(n_reg);
                    rsp_next.prime_value = '0;
                end
            end
            pse_pkg::ST_READ:
            begin
                done_next            = 1'b1;
                rsp_next.status      = out_of_range ? pse_pkg::STATUS_RANGE
                                                    : pse_pkg::STATUS_OK;
                rsp_next.prime_count = pse_pkg::count_t'(count_reg);
                rsp_next.prime_value = out_of_range ? '0 : pse_pkg::value_t'(list_rdata);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pse_pkg::ST_IDLE;
            count_reg    <= '0;
            pv_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pv_valid_reg <= pv_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= lim_next;
        v_reg   <= v_next;
        sq_reg  <= sq_next;
        m_reg   <= m_next;
        n_reg   <= n_next;
        pv_reg  <= pv_next;
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/prime_sieve_engine.sv @@
// Run item (limit L >= 2): clear, sieve and collect each walk the mark store, which has
// one write port and one read port.
// Run item with L < 2: result in the cycle after accept. Read item: result after the ST_READ state.
// One item at a time; busy is high after accept until the result strobe, except for a run with L < 2.
// done is high for one cycle per item; the receiver cannot stall.
// Reset clears the sequencer and the prime count; the stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module prime_sieve_engine #(
    parameter int LIMIT_CAP  = 65535,
    parameter int MAX_PRIMES = 8192
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pse_pkg::req_t request,
    output logic               done,
    output pse_pkg::rsp_t      response
);

    localparam int VW = $clog2(LIMIT_CAP + 1);
    localparam int PW = $clog2(MAX_PRIMES);

    logic          mark_we, mark_wdata, mark_rdata;
    logic [VW-1:0] mark_waddr, mark_raddr;
    logic          list_we;
    logic [PW-1:0] list_waddr, list_raddr;
    logic [VW-1:0] list_wdata, list_rdata;

    pse_seq #(
        .LIMIT_CAP  (LIMIT_CAP),
        .MAX_PRIMES (MAX_PRIMES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .request    (request),
        .done       (done),
        .response   (response),
        .mark_we    (mark_we),
        .mark_waddr (mark_waddr),
        .mark_wdata (mark_wdata),
        .mark_raddr (mark_raddr),
        .mark_rdata (mark_rdata),
        .list_we    (list_we),
        .list_waddr (list_waddr),
        .list_wdata (list_wdata),
        .list_raddr (list_raddr),
        .list_rdata (list_rdata)
    );

    pse_ram #(
        .DW    (1),
        .DEPTH (LIMIT_CAP + 1)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    pse_ram #(
        .DW    (VW),
        .DEPTH (MAX_PRIMES)
    ) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

endmodule

`default_nettype wire

@@ rtl/core/pse_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pse_chk (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire pse_pkg::req_t request,
    input wire logic          done,
    input wire pse_pkg::rsp_t response
);

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.command == pse_pkg::CMD_READ) |=> busy ##1 done)
        else $error("read item did not complete in two cycles");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status == pse_pkg::STATUS_RANGE) |-> response.prime_value == '0)
        else $error("out of range read returned nonzero value");

endmodule

bind prime_sieve_engine pse_chk u_pse_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .response (response)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT_CAP    = 65535;
    localparam int MAX_PRIMES   = 8192;
    localparam int RANDOM_ITEMS = 75;
    localparam int CYCLE_LIMIT  = 3_000_000;

    typedef struct
    {
        pse_pkg::req_t rq;
        bit            typed;
        pse_pkg::rsp_t want;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic          done;
    pse_pkg::req_t request;
    pse_pkg::rsp_t response;

    bit              composite [0:LIMIT_CAP];
    pse_pkg::value_t prime_list [0:MAX_PRIMES-1];
    int              prime_total = 0;
    pse_pkg::rsp_t   pending_replies [$];
    row_t            directed [$];
    int              errors = 0;
    int              cycles = 0;

    prime_sieve_engine u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic pse_pkg::rsp_t sieve_reply(pse_pkg::req_t rq);
        pse_pkg::rsp_t r;
        int            lim;
        int            n;
        r = '0;
        if (rq.command == pse_pkg::CMD_RUN)
        begin
            lim = (rq.limit > LIMIT_CAP) ? LIMIT_CAP : int'(rq.limit);
            n = 0;
            if (lim >= pse_pkg::FIRST_PRIME)
            begin
                for (int v = 0; v <= lim; v++)
                    composite[v] = 1'b0;
                composite[0] = 1'b1;
                composite[1] = 1'b1;
                for (int v = pse_pkg::FIRST_PRIME; v * v <= lim; v++)
                    if (!composite[v])
                        for (int m = v * v; m <= lim; m += v)
                            composite[m] = 1'b1;
                for (int v = pse_pkg::FIRST_PRIME; v <= lim; v++)
                begin
                    if (!composite[v] && n < MAX_PRIMES)
                    begin
                        prime_list[n] = pse_pkg::value_t'(v);
                        n++;
                    end
                end
            end
            prime_total = n;
            r.status = pse_pkg::STATUS_OK;
        end
        else if (rq.index >= prime_total || rq.index >= MAX_PRIMES)
            r.status = pse_pkg::STATUS_RANGE;
        else
        begin
            r.status = pse_pkg::STATUS_OK;
            r.prime_value = prime_list[rq.index];
        end
        r.prime_count = pse_pkg::count_t'(prime_total);
        return r;
    endfunction

    function automatic void add_row(pse_pkg::cmd_t c, int lim, int idx, bit typed,
                                    logic st, int cnt, int val);
        row_t x;
        x.rq.command       = c;
        x.rq.limit         = pse_pkg::limit_t'(lim);
        x.rq.index         = pse_pkg::index_t'(idx);
        x.typed            = typed;
        x.want.status      = st;
        x.want.prime_count = pse_pkg::count_t'(cnt);
        x.want.prime_value = pse_pkg::value_t'(val);
        directed.push_back(x);
    endfunction

    task automatic issue(pse_pkg::req_t rq, int gap, bit typed, pse_pkg::rsp_t want);
        pse_pkg::rsp_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= rq;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = sieve_reply(rq);
        pending_replies.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pse_pkg::rsp_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result: status %0d count %0d value %0d",
                       response.status, response.prime_count, response.prime_value);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (response.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, response.status);
                    errors++;
                end
                if (response.prime_count !== want.prime_count)
                begin
                    $error("prime_count: expected %0d, got %0d",
                           want.prime_count, response.prime_count);
                    errors++;
                end
                if (response.prime_value !== want.prime_value)
                begin
                    $error("prime_value: expected %0d, got %0d",
                           want.prime_value, response.prime_value);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        pse_pkg::req_t rq;
        int            gap;
        int            pick;
        bit            quiet;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        quiet   = 1'b0;

        // reads before any run are all out of range
        add_row(pse_pkg::CMD_READ, 0,     0,    1, pse_pkg::STATUS_RANGE, 0, 0);
        add_row(pse_pkg::CMD_READ, 65535, 8191, 1, pse_pkg::STATUS_RANGE, 0, 0);
        add_row(pse_pkg::CMD_RUN,  0,     0,    1, pse_pkg::STATUS_OK,    0, 0);
        add_row(pse_pkg::CMD_RUN,  1,     8191, 1, pse_pkg::STATUS_OK,    0, 0);
        add_row(pse_pkg::CMD_READ, 0,     0,    1, pse_pkg::STATUS_RANGE, 0, 0);
        add_row(pse_pkg::CMD_RUN,  2,     0,    1, pse_pkg::STATUS_OK,    1, 0);
        add_row(pse_pkg::CMD_READ, 0,     0,    1, pse_pkg::STATUS_OK,    1, 2);
        add_row(pse_pkg::CMD_READ, 0,     1,    1, pse_pkg::STATUS_RANGE, 1, 0);
        add_row(pse_pkg::CMD_RUN,  3,     0,    1, pse_pkg::STATUS_OK,    2, 0);
        add_row(pse_pkg::CMD_RUN,  4,     0,    1, pse_pkg::STATUS_OK,    2, 0);
        add_row(pse_pkg::CMD_READ, 0,     1,    1, pse_pkg::STATUS_OK,    2, 3);
        add_row(pse_pkg::CMD_RUN,  100,   0,    1, pse_pkg::STATUS_OK,    25, 0);
        add_row(pse_pkg::CMD_READ, 0,     24,   1, pse_pkg::STATUS_OK,    25, 97);
        add_row(pse_pkg::CMD_READ, 0,     25,   1, pse_pkg::STATUS_RANGE, 25, 0);
        add_row(pse_pkg::CMD_RUN,  65535, 0,    1, pse_pkg::STATUS_OK,    6542, 0);
        add_row(pse_pkg::CMD_READ, 0,     0,    1, pse_pkg::STATUS_OK,    6542, 2);
        add_row(pse_pkg::CMD_READ, 0,     6541, 1, pse_pkg::STATUS_OK,    6542, 65521);
        add_row(pse_pkg::CMD_READ, 0,     6542, 1, pse_pkg::STATUS_RANGE, 6542, 0);
        add_row(pse_pkg::CMD_READ, 0,     8191, 1, pse_pkg::STATUS_RANGE, 6542, 0);
        add_row(pse_pkg::CMD_READ, 0,     4095, 0, pse_pkg::STATUS_OK,    0, 0);
        add_row(pse_pkg::CMD_READ, 65535, 1000, 0, pse_pkg::STATUS_OK,    0, 0);
        add_row(pse_pkg::CMD_RUN,  30,    8191, 1, pse_pkg::STATUS_OK,    10, 0);
        add_row(pse_pkg::CMD_READ, 65535, 9,    1, pse_pkg::STATUS_OK,    10, 29);
        add_row(pse_pkg::CMD_RUN,  97,    0,    0, pse_pkg::STATUS_OK,    0, 0);
        add_row(pse_pkg::CMD_READ, 0,     24,   0, pse_pkg::STATUS_OK,    0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            gap = (i % 8 < 4) ? 0 : $urandom_range(0, 12);
            issue(directed[i].rq, gap, directed[i].typed, directed[i].want);
        end

        // mostly small sieves, with reads mostly inside the list and some past its end
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 16 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, 12);
            rq.limit = pse_pkg::limit_t'($urandom);
            rq.index = pse_pkg::index_t'($urandom);
            if (prime_total == 0 || $urandom_range(0, 99) < 30)
            begin
                rq.command = pse_pkg::CMD_RUN;
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    rq.limit = pse_pkg::limit_t'($urandom_range(0, 3));
                else if (pick < 75)
                    rq.limit = pse_pkg::limit_t'($urandom_range(4, 300));
                else
                    rq.limit = pse_pkg::limit_t'($urandom_range(301, 4095));
            end
            else
            begin
                rq.command = pse_pkg::CMD_READ;
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    rq.index = pse_pkg::index_t'($urandom_range(0, prime_total - 1));
                else if (pick < 90)
                    rq.index = pse_pkg::index_t'(prime_total + $urandom_range(0, 3));
            end
            issue(rq, gap, 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
